>>> rtl/mbrtu_pkg.sv
package mbrtu_pkg;

  // Item on the request channel
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_item_t;

  // Item on the response channel
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } out_item_t;

  // Function codes
  localparam logic [7:0] FN_RD_COILS = 8'd1;
  localparam logic [7:0] FN_RD_DISC  = 8'd2;
  localparam logic [7:0] FN_RD_HOLD  = 8'd3;
  localparam logic [7:0] FN_RD_INPUT = 8'd4;
  localparam logic [7:0] FN_WR_COIL  = 8'd5;
  localparam logic [7:0] FN_WR_REG   = 8'd6;
  localparam logic [7:0] FN_WR_COILS = 8'd15;
  localparam logic [7:0] FN_WR_REGS  = 8'd16;

  // Exception codes
  localparam logic [7:0] EXC_ILLEGAL_FN    = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_ADDR  = 8'h02;
  localparam logic [7:0] EXC_ILLEGAL_VALUE = 8'h03;
  localparam logic [7:0] EXC_FLAG          = 8'h80;

  localparam logic [7:0]  COIL_ON      = 8'hFF;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] INREG_OFFSET = 16'd100;
  localparam logic [15:0] PROC_WORD    = 16'd1111;
  localparam int unsigned FIXED_LEN    = 8;
  localparam int unsigned HDR_BYTES    = 7;

  // Controller states
  typedef enum logic [2:0] {
    ST_RECV,
    ST_HDR,
    ST_DECIDE,
    ST_WR_ADDR,
    ST_WR_DATA,
    ST_RESP
  } state_e;

  // Response kinds
  typedef enum logic [2:0] {
    RK_NONE,
    RK_EXC,
    RK_ECHO,
    RK_BITS,
    RK_WORDS
  } resp_kind_e;

  typedef struct packed {
    logic rx_en;
    logic hdr_step;
    logic decide;
    logic wr_addr;
    logic wr_data;
    logic resp_step;
  } cmd_t;

  typedef struct packed {
    logic frame_done;
    logic hdr_done;
    logic dec_none;
    logic dec_write;
    logic wr_last;
    logic resp_end;
  } status_t;

  // CRC-16 over one byte, reflected polynomial
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/modbus_rtu_slave_register_map.sv
// Modbus RTU slave with a small register map.
// Request channel: in_valid_i / in_stall_o carry one frame byte per item,
// with frame_end set on the last byte. Bytes are taken one per cycle while
// a frame is being received; in_stall_o rises once the frame end is taken.
// The frame is then checked (length, slave id, CRC) and served: the header is
// loaded from the frame store and decoded, and for multi-write functions each
// data byte is read and then written, all paced by the single read port of
// the frame store. The response then streams out one byte per cycle on
// out_valid_o / out_stall_i, CRC low byte then high byte, tx_last on the
// final byte. A stall on the output holds the byte in the output register
// and pauses the stream. Frames that get no answer return to receive right
// after decode. Configuration: cfg_valid_i / cfg_ready_o write slave_id;
// cfg_ready_o is always high.
// Reset: slave_id is 1, coils are set at even addresses, holding registers
// hold four times their address, counters are zero, the frame is empty.
module modbus_rtu_slave_register_map
  import mbrtu_pkg::*;
#(
  parameter int unsigned FRAME_BYTES    = 256,
  parameter int unsigned NUM_COILS      = 20,
  parameter int unsigned NUM_HOLDING    = 10,
  parameter int unsigned NUM_INPUT_REGS = 20,
  parameter int unsigned NUM_DISCRETE   = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign in_stall_o  = ~cmd.rx_en;
  assign cfg_ready_o = 1'b1;

  mbrtu_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  mbrtu_dp #(
    .FRAME_BYTES    (FRAME_BYTES),
    .NUM_COILS      (NUM_COILS),
    .NUM_HOLDING    (NUM_HOLDING),
    .NUM_INPUT_REGS (NUM_INPUT_REGS),
    .NUM_DISCRETE   (NUM_DISCRETE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/mbrtu_ctrl.sv
module mbrtu_ctrl
  import mbrtu_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RECV;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_RECV: begin
        cmd_o.rx_en = 1'b1;
        if (status_i.frame_done) state_d = ST_HDR;
      end
      ST_HDR: begin
        cmd_o.hdr_step = 1'b1;
        if (status_i.hdr_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        priority if (status_i.dec_none) state_d = ST_RECV;
        else if (status_i.dec_write)    state_d = ST_WR_ADDR;
        else                            state_d = ST_RESP;
      end
      ST_WR_ADDR: begin
        cmd_o.wr_addr = 1'b1;
        state_d       = ST_WR_DATA;
      end
      ST_WR_DATA: begin
        cmd_o.wr_data = 1'b1;
        state_d       = status_i.wr_last ? ST_RESP : ST_WR_ADDR;
      end
      ST_RESP: begin
        cmd_o.resp_step = 1'b1;
        if (status_i.resp_end) state_d = ST_RECV;
      end
      default: state_d = ST_RECV;
    endcase
  end

endmodule

>>> rtl/mbrtu_dp.sv
module mbrtu_dp
  import mbrtu_pkg::*;
#(
  parameter int unsigned FRAME_BYTES    = 256,
  parameter int unsigned NUM_COILS      = 20,
  parameter int unsigned NUM_HOLDING    = 10,
  parameter int unsigned NUM_INPUT_REGS = 20,
  parameter int unsigned NUM_DISCRETE   = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  input  logic      in_valid_i,
  input  in_item_t  in_data_i,
  input  logic      cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_item_t out_data_o
);

  localparam int unsigned AW  = $clog2(FRAME_BYTES);
  localparam int unsigned LW  = AW + 1;
  localparam int unsigned CIW = (NUM_COILS > 1) ? $clog2(NUM_COILS) : 1;
  localparam int unsigned HIW = (NUM_HOLDING > 1) ? $clog2(NUM_HOLDING) : 1;

  // Frame store and receive state
  logic [7:0]    mem [FRAME_BYTES];
  logic [7:0]    rd_q;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] len_q;
  logic [15:0]   rxcrc_q;
  logic [7:0]    slave_id_q;
  logic          rx_acc;

  // Header bytes 0..6
  logic [HDR_BYTES-1:0][7:0] h_q;
  logic [2:0]                hcnt_q;

  // Register map and statistics
  logic [NUM_COILS-1:0]         coils_q, coils_d;
  logic [NUM_HOLDING-1:0][15:0] hold_q, hold_d;
  logic [15:0] req_q, bin_q, bout_q, iw2_q;
  logic        seen_q;

  // Response and write-loop state
  resp_kind_e    kind_q;
  logic [7:0]    rcount_q;
  logic [8:0]    blen_q, idx_q;
  logic [15:0]   ptr_q, rem_q, txcrc_q;
  logic          aux_q, wregs_q, wph_q;
  logic [7:0]    hi_q;
  logic [AW-1:0] wptr_q;
  logic          tx_valid_q;
  out_item_t     tx_q;

  assign rx_acc = in_valid_i && cmd_i.rx_en;

  // Frame store: one write port, one registered read port
  always_comb begin
    priority if (cmd_i.hdr_step) rd_addr = AW'(hcnt_q);
    else                         rd_addr = wptr_q;
  end

  always_ff @(posedge clk_i) begin
    if (rx_acc && (len_q < LW'(FRAME_BYTES))) mem[len_q[AW-1:0]] <= in_data_i.rx_byte;
    if (cmd_i.hdr_step || cmd_i.wr_addr) rd_q <= mem[rd_addr];
  end

  // Decode of the finished frame
  logic [7:0]  fn;
  logic [15:0] a, n, a4;
  logic [16:0] nbytes;
  logic        crc_ok, len_ok;
  resp_kind_e  dkind;
  logic [7:0]  dcount;
  logic [15:0] dptr;
  logic        dwrite, daux, dset_coil, dset_hold;

  function automatic logic in_rng(input logic [15:0] off, input logic [15:0] cnt,
                                  input logic [16:0] size);
    return (17'(off) < size) && ((17'(off) + 17'(cnt)) <= size);
  endfunction

  always_comb begin
    fn        = h_q[1];
    a         = {h_q[2], h_q[3]};
    n         = {h_q[4], h_q[5]};
    a4        = a - INREG_OFFSET;
    nbytes    = (17'(n) + 17'd7) >> 3;
    crc_ok    = (len_q >= LW'(2)) && (rxcrc_q == 16'h0000);
    dkind     = RK_NONE;
    dcount    = EXC_ILLEGAL_FN;
    dptr      = a;
    dwrite    = 1'b0;
    daux      = 1'b0;
    dset_coil = 1'b0;
    dset_hold = 1'b0;
    len_ok    = 1'b1;
    if ((fn >= FN_RD_COILS) && (fn <= FN_WR_REG)) begin
      len_ok = (len_q == LW'(FIXED_LEN));
    end else if ((fn == FN_WR_COILS) || (fn == FN_WR_REGS)) begin
      len_ok = (10'(len_q) == (10'd9 + 10'(h_q[6])));
    end
    if (len_q >= LW'(2)) begin
      if (!len_ok) begin
        dkind  = RK_EXC;
        dcount = EXC_ILLEGAL_VALUE;
      end else if ((h_q[0] == slave_id_q) && crc_ok) begin
        dkind  = RK_EXC;
        dcount = EXC_ILLEGAL_FN;
        unique case (fn)
          FN_RD_COILS, FN_RD_DISC: begin
            daux = (fn == FN_RD_DISC);
            priority if (!in_rng(a, n, daux ? 17'(NUM_DISCRETE) : 17'(NUM_COILS)))
              dcount = EXC_ILLEGAL_ADDR;
            else if (n == 16'd0) dcount = EXC_ILLEGAL_VALUE;
            else begin
              dkind  = RK_BITS;
              dcount = nbytes[7:0];
            end
          end
          FN_RD_HOLD, FN_RD_INPUT: begin
            daux = (fn == FN_RD_INPUT);
            dptr = daux ? a4 : a;
            priority if (!in_rng(dptr, n,
                                 daux ? 17'(NUM_INPUT_REGS) : 17'(NUM_HOLDING)))
              dcount = EXC_ILLEGAL_ADDR;
            else if (n == 16'd0) dcount = EXC_ILLEGAL_VALUE;
            else begin
              dkind  = RK_WORDS;
              dcount = 8'(n << 1);
            end
          end
          FN_WR_COIL: begin
            priority if (!in_rng(a, 16'd1, 17'(NUM_COILS))) dcount = EXC_ILLEGAL_ADDR;
            else if (((h_q[4] == COIL_ON) || (h_q[4] == 8'h00)) && (h_q[5] == 8'h00)) begin
              dkind     = RK_ECHO;
              dset_coil = 1'b1;
            end else dcount = EXC_ILLEGAL_VALUE;
          end
          FN_WR_REG: begin
            if (!in_rng(a, 16'd1, 17'(NUM_HOLDING))) dcount = EXC_ILLEGAL_ADDR;
            else begin
              dkind     = RK_ECHO;
              dset_hold = 1'b1;
            end
          end
          FN_WR_COILS: begin
            priority if (!in_rng(a, n, 17'(NUM_COILS))) dcount = EXC_ILLEGAL_ADDR;
            else if ((n == 16'd0) || (17'(h_q[6]) != nbytes)) dcount = EXC_ILLEGAL_VALUE;
            else begin
              dkind  = RK_ECHO;
              dwrite = 1'b1;
            end
          end
          FN_WR_REGS: begin
            priority if (!in_rng(a, n, 17'(NUM_HOLDING))) dcount = EXC_ILLEGAL_ADDR;
            else if ((n == 16'd0) || (17'(h_q[6]) != (17'(n) << 1)))
              dcount = EXC_ILLEGAL_VALUE;
            else begin
              dkind  = RK_ECHO;
              dwrite = 1'b1;
            end
          end
          default: dcount = EXC_ILLEGAL_FN;
        endcase
      end
    end
  end

  // Coil and holding register updates
  always_comb begin
    logic [15:0] p;
    coils_d = coils_q;
    hold_d  = hold_q;
    p       = '0;
    if (cmd_i.decide && dset_coil) coils_d[a[CIW-1:0]] = (h_q[4] == COIL_ON);
    if (cmd_i.decide && dset_hold) hold_d[a[HIW-1:0]] = n;
    if (cmd_i.wr_data && !wregs_q) begin
      for (int j = 0; j < 8; j++) begin
        p = ptr_q + 16'(j);
        if ((16'(j) < rem_q) && (p < 16'(NUM_COILS))) coils_d[p[CIW-1:0]] = rd_q[j];
      end
    end
    if (cmd_i.wr_data && wregs_q && wph_q && (ptr_q < 16'(NUM_HOLDING)))
      hold_d[ptr_q[HIW-1:0]] = {hi_q, rd_q};
  end

  // Response byte selection
  logic [7:0]  data_byte, stream_byte, cur_byte;
  logic [15:0] word;
  logic        fire, stream;

  always_comb begin
    logic [15:0] p;
    logic        b;
    p           = '0;
    b           = 1'b0;
    stream_byte = '0;
    if (kind_q == RK_BITS) begin
      for (int j = 0; j < 8; j++) begin
        p = ptr_q + 16'(j);
        if (aux_q) begin
          priority if (p == 16'd0) b = req_q[0];
          else if (p == 16'd1)     b = bin_q[0];
          else if (p == 16'd2)     b = iw2_q[0];
          else if (p == 16'd13)    b = seen_q;
          else                     b = 1'b0;
        end else begin
          b = (p < 16'(NUM_COILS)) ? coils_q[p[CIW-1:0]] : 1'b0;
        end
        stream_byte[j] = (16'(j) < rem_q) && b;
      end
      word = '0;
    end else begin
      if (aux_q) begin
        priority if (ptr_q == 16'd0) word = req_q;
        else if (ptr_q == 16'd1)     word = bin_q;
        else if (ptr_q == 16'd2)     word = iw2_q;
        else if ((ptr_q >= 16'd13) && ptr_q[0] && (ptr_q < 16'(NUM_INPUT_REGS)))
          word = PROC_WORD;
        else word = '0;
      end else begin
        word = (ptr_q < 16'(NUM_HOLDING)) ? hold_q[ptr_q[HIW-1:0]] : '0;
      end
      stream_byte = wph_q ? word[7:0] : word[15:8];
    end
  end

  always_comb begin
    stream = (idx_q >= 9'd3) && ((kind_q == RK_BITS) || (kind_q == RK_WORDS));
    priority if (idx_q == 9'd0) data_byte = h_q[0];
    else if (idx_q == 9'd1)     data_byte = (kind_q == RK_EXC) ? (h_q[1] | EXC_FLAG) : h_q[1];
    else if (idx_q == 9'd2)     data_byte = (kind_q == RK_ECHO) ? h_q[2] : rcount_q;
    else if (kind_q == RK_ECHO) data_byte = h_q[idx_q[2:0]];
    else                        data_byte = stream_byte;
    priority if (idx_q < blen_q) cur_byte = data_byte;
    else if (idx_q == blen_q)    cur_byte = txcrc_q[7:0];
    else                         cur_byte = txcrc_q[15:8];
    fire = cmd_i.resp_step && (!tx_valid_q || !out_stall_i);
  end

  // Status to the controller
  always_comb begin
    status_o            = '0;
    status_o.frame_done = rx_acc && in_data_i.frame_end;
    status_o.hdr_done   = (hcnt_q == 3'(HDR_BYTES));
    status_o.dec_none   = (dkind == RK_NONE);
    status_o.dec_write  = dwrite;
    status_o.wr_last    = wregs_q ? (wph_q && (rem_q == 16'd1)) : (rem_q <= 16'd8);
    status_o.resp_end   = fire && (idx_q == (blen_q + 9'd1));
  end

  // Control and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      rxcrc_q    <= CRC_INIT;
      slave_id_q <= 8'd1;
      hcnt_q     <= '0;
      req_q      <= '0;
      bin_q      <= '0;
      bout_q     <= '0;
      iw2_q      <= '0;
      seen_q     <= 1'b0;
      kind_q     <= RK_NONE;
      idx_q      <= '0;
      tx_valid_q <= 1'b0;
      for (int i = 0; i < NUM_COILS; i++) coils_q[i] <= ((i & 1) == 0);
      for (int i = 0; i < NUM_HOLDING; i++) hold_q[i] <= 16'(i * 4);
    end else begin
      coils_q <= coils_d;
      hold_q  <= hold_d;
      if (cfg_we_i) slave_id_q <= cfg_data_i;
      // receive
      if (rx_acc && (len_q < LW'(FRAME_BYTES))) begin
        len_q   <= len_q + LW'(1);
        rxcrc_q <= crc_byte(rxcrc_q, in_data_i.rx_byte);
      end
      // header load
      if (cmd_i.hdr_step) hcnt_q <= hcnt_q + 3'd1;
      // frame end bookkeeping
      if (cmd_i.decide) begin
        hcnt_q  <= '0;
        len_q   <= '0;
        rxcrc_q <= CRC_INIT;
        req_q   <= req_q + 16'd1;
        if (crc_ok) bin_q <= bin_q + (16'(len_q) - 16'd2);
        iw2_q   <= bout_q;
        seen_q  <= 1'b1;
        kind_q  <= dkind;
        idx_q   <= '0;
      end
      // response stream
      if (fire) begin
        idx_q <= idx_q + 9'd1;
        if (idx_q < blen_q) bout_q <= bout_q + 16'd1;
      end
      if (fire) tx_valid_q <= 1'b1;
      else if (!out_stall_i) tx_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_step && (hcnt_q != 3'd0))
      h_q[hcnt_q - 3'd1] <= (LW'(hcnt_q - 3'd1) < len_q) ? rd_q : 8'h00;
    if (cmd_i.decide) begin
      rcount_q <= dcount;
      blen_q   <= (dkind == RK_ECHO) ? 9'd6 : ((dkind == RK_EXC) ? 9'd3 : 9'd3 + 9'(dcount));
      ptr_q    <= dptr;
      rem_q    <= n;
      aux_q    <= daux;
      wregs_q  <= (fn == FN_WR_REGS);
      wph_q    <= 1'b0;
      wptr_q   <= AW'(HDR_BYTES);
      txcrc_q  <= CRC_INIT;
    end
    if (cmd_i.wr_data) begin
      wptr_q <= wptr_q + AW'(1);
      if (wregs_q) begin
        wph_q <= ~wph_q;
        if (!wph_q) hi_q <= rd_q;
        else begin
          ptr_q <= ptr_q + 16'd1;
          rem_q <= rem_q - 16'd1;
        end
      end else begin
        ptr_q <= ptr_q + 16'd8;
        rem_q <= rem_q - 16'd8;
      end
    end
    if (fire) begin
      tx_q.tx_byte <= cur_byte;
      tx_q.tx_last <= (idx_q == (blen_q + 9'd1));
      if (idx_q < blen_q) txcrc_q <= crc_byte(txcrc_q, cur_byte);
      if (stream) begin
        if (kind_q == RK_BITS) begin
          ptr_q <= ptr_q + 16'd8;
          rem_q <= rem_q - 16'd8;
        end else begin
          wph_q <= ~wph_q;
          if (wph_q) ptr_q <= ptr_q + 16'd1;
        end
      end
    end
  end

  assign out_valid_o = tx_valid_q;
  assign out_data_o  = tx_q;

endmodule

>>> verif/modbus_rtu_slave_register_map_tb.sv
module modbus_rtu_slave_register_map_tb;
  import mbrtu_pkg::*;

  localparam int NCOIL = 20;
  localparam int NHOLD = 10;
  localparam int NINREG = 20;
  localparam int NDISC = 20;
  localparam int FBYTES = 256;
  localparam int CYCLE_LIMIT = 600000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [7:0] cfg_data_i = 8'd0;

  modbus_rtu_slave_register_map i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Slave state as the predictor sees it
  logic [7:0]  frame_buf [FBYTES];
  int          frame_len;
  logic [15:0] crc_acc;
  logic        coils [NCOIL];
  logic [15:0] hold_regs [NHOLD];
  logic [15:0] in_regs [NINREG];
  logic        disc_in [NDISC];
  logic [15:0] req_cnt, rx_cnt, tx_cnt;
  logic [7:0]  my_id;

  logic [7:0]  reply [$];
  out_item_t   expected_bytes [$];
  in_item_t    pending_bytes [$];
  logic [7:0]  frame_q [$];
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  int          sent_cnt = 0;

  function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic logic [7:0] fbyte(int i);
    return (i < frame_len) ? frame_buf[i] : 8'h00;
  endfunction

  function automatic logic [15:0] fword(int i);
    return {fbyte(i), fbyte(i + 1)};
  endfunction

  function automatic void reply_exc(logic [7:0] code);
    reply = {};
    reply.push_back(fbyte(0));
    reply.push_back(fbyte(1) | EXC_FLAG);
    reply.push_back(code);
  endfunction

  function automatic void reply_echo();
    reply = {};
    for (int i = 0; i < 6; i++) reply.push_back(fbyte(i));
  endfunction

  function automatic bit fits(int size, int off, int n);
    return off < size && off + n <= size;
  endfunction

  // Serve a checked request, building the reply body
  function automatic void serve_request(logic [7:0] fn);
    logic [15:0] a, n, off;
    int nb;
    logic [7:0] acc;
    a = fword(2);
    n = fword(4);
    case (fn)
      FN_RD_COILS, FN_RD_DISC: begin
        if (!fits(fn == FN_RD_COILS ? NCOIL : NDISC, a, n)) reply_exc(EXC_ILLEGAL_ADDR);
        else if (n == 0) reply_exc(EXC_ILLEGAL_VALUE);
        else begin
          nb = (n + 7) / 8;
          reply = {fbyte(0), fbyte(1), 8'(nb)};
          for (int j = 0; j < nb; j++) begin
            acc = 8'h00;
            for (int k = 0; k < 8; k++)
              if (j * 8 + k < n)
                acc[k] = (fn == FN_RD_COILS) ? coils[a + j * 8 + k] : disc_in[a + j * 8 + k];
            reply.push_back(acc);
          end
        end
      end
      FN_RD_HOLD, FN_RD_INPUT: begin
        off = (fn == FN_RD_HOLD) ? a : a - INREG_OFFSET;
        if (!fits(fn == FN_RD_HOLD ? NHOLD : NINREG, off, n)) reply_exc(EXC_ILLEGAL_ADDR);
        else if (n == 0) reply_exc(EXC_ILLEGAL_VALUE);
        else begin
          reply = {fbyte(0), fbyte(1), 8'(2 * n)};
          for (int i = 0; i < n; i++) begin
            if (fn == FN_RD_HOLD) begin
              reply.push_back(hold_regs[off + i][15:8]);
              reply.push_back(hold_regs[off + i][7:0]);
            end else begin
              reply.push_back(in_regs[off + i][15:8]);
              reply.push_back(in_regs[off + i][7:0]);
            end
          end
        end
      end
      FN_WR_COIL: begin
        if (!fits(NCOIL, a, 1)) reply_exc(EXC_ILLEGAL_ADDR);
        else if (n == {COIL_ON, 8'h00}) begin coils[a] = 1'b1; reply_echo(); end
        else if (n == 16'h0000) begin coils[a] = 1'b0; reply_echo(); end
        else reply_exc(EXC_ILLEGAL_VALUE);
      end
      FN_WR_REG: begin
        if (!fits(NHOLD, a, 1)) reply_exc(EXC_ILLEGAL_ADDR);
        else begin hold_regs[a] = n; reply_echo(); end
      end
      FN_WR_COILS: begin
        if (!fits(NCOIL, a, n)) reply_exc(EXC_ILLEGAL_ADDR);
        else if (n == 0 || fbyte(6) != (n + 7) / 8) reply_exc(EXC_ILLEGAL_VALUE);
        else begin
          for (int i = 0; i < n; i++) coils[a + i] = fbyte(7 + i / 8) >> (i % 8);
          reply_echo();
        end
      end
      FN_WR_REGS: begin
        if (!fits(NHOLD, a, n)) reply_exc(EXC_ILLEGAL_ADDR);
        else if (n == 0 || fbyte(6) != 2 * n) reply_exc(EXC_ILLEGAL_VALUE);
        else begin
          for (int i = 0; i < n; i++) hold_regs[a + i] = fword(7 + 2 * i);
          reply_echo();
        end
      end
      default: reply_exc(EXC_ILLEGAL_FN);
    endcase
  endfunction

  // Append the reply with its CRC to the expected stream
  function automatic void queue_reply();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (reply[i]) c = crc_next(c, reply[i]);
    tx_cnt = tx_cnt + 16'(reply.size());
    reply.push_back(c[7:0]);
    reply.push_back(c[15:8]);
    foreach (reply[i]) expected_bytes.push_back('{tx_byte: reply[i], tx_last: i == reply.size() - 1});
  endfunction

  // Predict one accepted request byte
  function automatic void predict_byte(in_item_t it);
    bit ok_len, crc_good;
    logic [7:0] fn;
    if (frame_len < FBYTES) begin
      frame_buf[frame_len] = it.rx_byte;
      frame_len++;
      crc_acc = crc_next(crc_acc, it.rx_byte);
    end
    if (!it.frame_end) return;
    crc_good = frame_len >= 2 && crc_acc == 16'h0000;
    req_cnt++;
    if (crc_good) rx_cnt = rx_cnt + 16'(frame_len - 2);
    in_regs[0] = req_cnt;
    in_regs[1] = rx_cnt;
    in_regs[2] = tx_cnt;
    for (int i = 3; i < 13; i++) in_regs[i] = 16'h0000;
    for (int i = 0; i < 15; i++) disc_in[i] = in_regs[i][0];
    if (frame_len >= 2) begin
      fn = fbyte(1);
      ok_len = 1'b1;
      if (fn >= FN_RD_COILS && fn <= FN_WR_REG) ok_len = frame_len == FIXED_LEN;
      else if (fn == FN_WR_COILS || fn == FN_WR_REGS)
        ok_len = frame_len >= HDR_BYTES && frame_len == 9 + fbyte(6);
      if (!ok_len) begin reply_exc(EXC_ILLEGAL_VALUE); queue_reply(); end
      else if (fbyte(0) == my_id && crc_good) begin serve_request(fn); queue_reply(); end
    end
    frame_len = 0;
    crc_acc = CRC_INIT;
  endfunction

  // Frame helpers: fill frame_q then push it with CRC (or broken CRC)
  task automatic push_frame(bit good_crc);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_q[i]) c = crc_next(c, frame_q[i]);
    if (!good_crc) c = c ^ 16'(1 << $urandom_range(15));
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
    foreach (frame_q[i]) pending_bytes.push_back('{rx_byte: frame_q[i], frame_end: i == frame_q.size() - 1});
    frame_q = {};
  endtask

  task automatic fixed_req(logic [7:0] id, logic [7:0] fn, logic [15:0] a, logic [15:0] n,
                           bit good_crc = 1);
    frame_q = {id, fn, a[15:8], a[7:0], n[15:8], n[7:0]};
    push_frame(good_crc);
  endtask

  task automatic multi_req(logic [7:0] id, logic [7:0] fn, logic [15:0] a, logic [15:0] n,
                           int cnt, bit good_crc = 1);
    frame_q = {id, fn, a[15:8], a[7:0], n[15:8], n[7:0], 8'(cnt)};
    for (int i = 0; i < cnt; i++) frame_q.push_back(8'($urandom));
    push_frame(good_crc);
  endtask

  task automatic raw_frame(int len);
    for (int i = 0; i < len; i++)
      pending_bytes.push_back('{rx_byte: 8'($urandom), frame_end: i == len - 1});
  endtask

  // Wait until every byte is taken and every response has left
  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid_i || expected_bytes.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_id(logic [7:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    my_id = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_fn();
    logic [7:0] fns[8] = '{FN_RD_COILS, FN_RD_DISC, FN_RD_HOLD, FN_RD_INPUT,
                           FN_WR_COIL, FN_WR_REG, FN_WR_COILS, FN_WR_REGS};
    return fns[$urandom_range(7)];
  endfunction

  // Random, mostly well-formed requests
  task automatic random_traffic(int nbytes);
    int stop;
    logic [7:0] fn, id;
    logic [15:0] a, n;
    stop = sent_cnt + nbytes;
    while (sent_cnt + pending_bytes.size() < stop) begin
      id = ($urandom_range(9) != 0) ? my_id : 8'($urandom);
      fn = ($urandom_range(15) != 0) ? pick_fn() : 8'($urandom);
      case ($urandom_range(3))
        0: a = 16'($urandom);
        default: a = (fn == FN_RD_INPUT) ? 16'(100 + $urandom_range(21)) : 16'($urandom_range(21));
      endcase
      n = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(21));
      if (fn == FN_WR_COIL && $urandom_range(3) != 0) n = $urandom_range(1) ? 16'hFF00 : 16'h0;
      if (fn == FN_WR_COILS || fn == FN_WR_REGS) begin
        if ($urandom_range(5) != 0)
          n = (fn == FN_WR_COILS) ? 16'($urandom_range(1, 20)) : 16'($urandom_range(1, 10));
        multi_req(id, fn, a, n,
                  $urandom_range(5) == 0 ? $urandom_range(8) :
                  (fn == FN_WR_COILS ? (n + 7) / 8 : 2 * n) % 256, $urandom_range(9) != 0);
      end else if ($urandom_range(11) == 0) raw_frame($urandom_range(1, 12));
      else fixed_req(id, fn, a, n, $urandom_range(9) != 0);
    end
  endtask

  // Driver
  int in_gap = 0;
  logic in_taken = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        // previous item taken at the last rising edge
      end
      if (!in_valid_i || in_taken) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_data_i <= pending_bytes.pop_front();
          in_valid_i <= 1'b1;
          in_gap <= ($urandom_range(3) == 0) ? $urandom_range(7) : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Request acceptance and prediction
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_byte(in_data_i);
      sent_cnt++;
    end
  end

  // Response stall pattern
  int out_gap = 0;
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      out_gap <= ($urandom_range(3) == 0) ? $urandom_range(7) : 0;
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    out_item_t exp_item;
    cycle_cnt++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected response byte %h last %b", $time,
                 out_data_o.tx_byte, out_data_o.tx_last);
        fail_cnt++;
      end else begin
        exp_item = expected_bytes.pop_front();
        if (out_data_o.tx_byte !== exp_item.tx_byte || out_data_o.tx_last !== exp_item.tx_last) begin
          $display("%0t: mismatch expected byte %h last %b, actual byte %h last %b", $time,
                   exp_item.tx_byte, exp_item.tx_last, out_data_o.tx_byte, out_data_o.tx_last);
          fail_cnt++;
        end
      end
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    frame_len = 0;
    crc_acc = CRC_INIT;
    for (int i = 0; i < NCOIL; i++) coils[i] = (i % 2 == 0);
    for (int i = 0; i < NHOLD; i++) hold_regs[i] = 16'(i * 4);
    for (int i = 0; i < NINREG; i++) in_regs[i] = (i >= 13 && i % 2 == 1) ? PROC_WORD : 16'h0;
    for (int i = 0; i < NDISC; i++) disc_in[i] = 1'b0;
    req_cnt = 0;
    rx_cnt = 0;
    tx_cnt = 0;
    my_id = 8'd1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every function, extremes and error paths
    fixed_req(my_id, FN_RD_COILS, 0, 20);
    fixed_req(my_id, FN_RD_DISC, 0, 20);
    fixed_req(my_id, FN_RD_HOLD, 0, 10);
    fixed_req(my_id, FN_RD_INPUT, 100, 20);
    fixed_req(my_id, FN_RD_INPUT, 16'hFFFF, 16'hFFFF);
    fixed_req(my_id, FN_WR_COIL, 19, 16'hFF00);
    fixed_req(my_id, FN_WR_COIL, 0, 16'h1234);
    fixed_req(my_id, FN_WR_REG, 9, 16'hFFFF);
    fixed_req(my_id, FN_RD_HOLD, 5, 0);
    fixed_req(my_id, FN_RD_COILS, 19, 2);
    fixed_req(my_id, 8'hFF, 0, 1);
    fixed_req(8'h55, FN_RD_HOLD, 0, 1);
    fixed_req(my_id, FN_RD_HOLD, 0, 1, 0);
    multi_req(my_id, FN_WR_COILS, 0, 20, 3);
    multi_req(my_id, FN_WR_REGS, 0, 10, 20);
    multi_req(my_id, FN_WR_REGS, 0, 2, 3);
    raw_frame(1);
    raw_frame(5);
    drain();

    write_id(8'd0);
    random_traffic(25);
    drain();
    write_id(8'd255);
    fixed_req(8'd255, FN_RD_INPUT, 100, 20);
    random_traffic(25);
    drain();
    write_id(8'($urandom));
    random_traffic(25);
    drain();

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
